// ===== hw/rtl/vwsm_pkg.sv =====
// shared types and constants of the virtual wire signal mirror
package vwsm_pkg;

   // request type codes
   localparam logic [2:0] REQ_BUS_RESET   = 3'd0;
   localparam logic [2:0] REQ_CHAN_STATUS = 3'd1;
   localparam logic [2:0] REQ_WIRE_RX     = 3'd2;
   localparam logic [2:0] REQ_INIT_VALUE  = 3'd3;
   localparam logic [2:0] REQ_QUERY       = 3'd4;

   // result kind codes
   localparam logic KIND_NOTIFY = 1'b0;
   localparam logic KIND_REPLY  = 1'b1;

   // configuration register indexes
   localparam logic [1:0] CSR_WIRE_ID_MAP  = 2'd0;
   localparam logic [1:0] CSR_INVERT_MASK  = 2'd1;
   localparam logic [1:0] CSR_RESET_LEVEL  = 2'd2;

   // field widths
   localparam int TYPE_W   = 3;
   localparam int ID_W     = 8;
   localparam int INDEX_W  = 8;
   localparam int SLOT_W   = 3;
   localparam int CSR_A_W  = 2;
   localparam int CSR_D_W  = 64;
   localparam int REQ_D_W  = 24;
   localparam int RSP_D_W  = 8;

   // controller to datapath
   typedef struct packed {
      logic load;     // latch the accepted word
      logic emit;     // put one result into the output register
      logic advance;  // step the slot counter
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic needs_run;  // accepted word produces results
      logic out_free;   // output register can take a result
      logic hit;        // result pending at the current step
      logic final_hit;  // no result pending after this one
   } status_type;

endpackage

// ===== hw/rtl/vwsm_ctrl.sv =====
// controller state machine of the virtual wire signal mirror
module vwsm_ctrl
   import vwsm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type sts,
   output cmd_type    cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   logic state_ff;
   logic state_in;
   logic accept;

   // handshake and commands
   always_comb begin
      req_tready  = (state_ff == ST_IDLE);
      accept      = req_tvalid && req_tready;
      cmd.load    = accept;
      cmd.advance = (state_ff == ST_RUN) && sts.out_free;
      cmd.emit    = (state_ff == ST_RUN) && sts.out_free && sts.hit;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && sts.needs_run) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (cmd.emit && sts.final_hit) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hw/rtl/vwsm_dp.sv =====
// datapath of the virtual wire signal mirror: settings, slot state, scan and output register
module vwsm_dp
   import vwsm_pkg::*;
#(
   parameter int NUM_SIGNALS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [CSR_A_W-1:0] csr_addr,
   input  logic [CSR_D_W-1:0] csr_wdata,
   input  logic [TYPE_W-1:0]  req_type,
   input  logic               event_level,
   input  logic               is_wire_channel,
   input  logic [ID_W-1:0]    wire_id,
   input  logic [INDEX_W-1:0] slot_index,
   input  cmd_type            cmd,
   output status_type         sts,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic               result_kind,
   output logic [SLOT_W-1:0]  slot_number,
   output logic               level,
   output logic               query_error,
   output logic               last
);

   localparam int N     = NUM_SIGNALS;
   localparam int CNT_W = (N > 1) ? $clog2(N) : 1;
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(N - 1);

   // settings
   logic [N*ID_W-1:0] id_map_ff;
   logic [N-1:0]      invert_ff;
   logic [N-1:0]      reset_level_ff;

   // slot state
   logic [N-1:0] levels_ff, levels_in;
   logic [N-1:0] valid_ff, valid_in;

   // scan state
   logic [N-1:0]     mask_ff, mask_in;
   logic [N-1:0]     vals_ff, vals_in;
   logic             query_ff, query_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             q_level_ff, q_level_in;
   logic             q_err_ff, q_err_in;
   logic [SLOT_W-1:0] q_slot_ff, q_slot_in;

   // output register
   logic              out_valid_ff, out_valid_in;
   logic              out_kind_ff, out_kind_in;
   logic [SLOT_W-1:0] out_slot_ff, out_slot_in;
   logic              out_level_ff, out_level_in;
   logic              out_err_ff, out_err_in;
   logic              out_last_ff, out_last_in;

   logic [N-1:0]     match;
   logic [N-1:0]     remaining;
   logic             idx_ok;
   logic [CNT_W-1:0] idx;

   // wire id compare, one per slot
   for (genvar s = 0; s < N; s++) begin : g_match
      assign match[s] = (id_map_ff[s*ID_W +: ID_W] == wire_id);
   end

   assign idx_ok = (slot_index < INDEX_W'(N));
   assign idx    = slot_index[CNT_W-1:0];

   // status toward the controller
   always_comb begin
      remaining          = mask_ff;
      remaining[cnt_ff]  = 1'b0;
      sts.out_free       = !out_valid_ff || rsp_tready;
      sts.hit            = query_ff || mask_ff[cnt_ff];
      sts.final_hit      = query_ff || (remaining == '0);
      sts.needs_run      = (req_type == REQ_QUERY)
                        || ((req_type == REQ_BUS_RESET) && event_level)
                        || ((req_type == REQ_WIRE_RX) && (match != '0));
   end

   // slot state and scan updates
   always_comb begin
      levels_in  = levels_ff;
      valid_in   = valid_ff;
      mask_in    = mask_ff;
      vals_in    = vals_ff;
      query_in   = query_ff;
      cnt_in     = cnt_ff;
      q_level_in = q_level_ff;
      q_err_in   = q_err_ff;
      q_slot_in  = q_slot_ff;
      if (cmd.load) begin
         mask_in  = '0;
         query_in = 1'b0;
         cnt_in   = '0;
         case (req_type)
            REQ_BUS_RESET: begin
               if (event_level) begin
                  mask_in = '1;
                  vals_in = reset_level_ff;
               end else begin
                  valid_in = '0;
               end
            end
            REQ_CHAN_STATUS: begin
               if (is_wire_channel && !event_level) begin
                  valid_in = '0;
               end
            end
            REQ_WIRE_RX: begin
               mask_in = match;
               vals_in = {N{event_level}} ^ invert_ff;
            end
            REQ_INIT_VALUE: begin
               if (idx_ok) begin
                  levels_in[idx] = event_level ^ invert_ff[idx];
                  valid_in[idx]  = 1'b1;
               end
            end
            REQ_QUERY: begin
               query_in = 1'b1;
               if (!idx_ok) begin
                  q_slot_in  = '0;
                  q_err_in   = 1'b1;
                  q_level_in = 1'b0;
               end else begin
                  q_slot_in  = slot_index[SLOT_W-1:0];
                  q_err_in   = !valid_ff[idx];
                  q_level_in = valid_ff[idx] && levels_ff[idx];
               end
            end
            default: begin
            end
         endcase
      end else begin
         if (cmd.emit) begin
            if (query_ff) begin
               query_in = 1'b0;
            end else begin
               levels_in[cnt_ff] = vals_ff[cnt_ff];
               valid_in[cnt_ff]  = 1'b1;
               mask_in[cnt_ff]   = 1'b0;
            end
         end
         if (cmd.advance) begin
            cnt_in = (cnt_ff == CNT_MAX) ? '0 : cnt_ff + 1'b1;
         end
      end
   end

   // output register
   always_comb begin
      out_valid_in = out_valid_ff && !rsp_tready;
      out_kind_in  = out_kind_ff;
      out_slot_in  = out_slot_ff;
      out_level_in = out_level_ff;
      out_err_in   = out_err_ff;
      out_last_in  = out_last_ff;
      if (cmd.emit) begin
         out_valid_in = 1'b1;
         out_last_in  = sts.final_hit;
         if (query_ff) begin
            out_kind_in  = KIND_REPLY;
            out_slot_in  = q_slot_ff;
            out_level_in = q_level_ff;
            out_err_in   = q_err_ff;
         end else begin
            out_kind_in  = KIND_NOTIFY;
            out_slot_in  = SLOT_W'(cnt_ff);
            out_level_in = vals_ff[cnt_ff];
            out_err_in   = 1'b0;
         end
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         id_map_ff      <= '0;
         invert_ff      <= '0;
         reset_level_ff <= '0;
         levels_ff      <= '0;
         valid_ff       <= '0;
         mask_ff        <= '0;
         query_ff       <= 1'b0;
         cnt_ff         <= '0;
         out_valid_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_WIRE_ID_MAP: id_map_ff      <= csr_wdata[N*ID_W-1:0];
               CSR_INVERT_MASK: invert_ff      <= csr_wdata[N-1:0];
               CSR_RESET_LEVEL: reset_level_ff <= csr_wdata[N-1:0];
               default: begin
               end
            endcase
         end
         levels_ff    <= levels_in;
         valid_ff     <= valid_in;
         mask_ff      <= mask_in;
         query_ff     <= query_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      vals_ff      <= vals_in;
      q_level_ff   <= q_level_in;
      q_err_ff     <= q_err_in;
      q_slot_ff    <= q_slot_in;
      out_kind_ff  <= out_kind_in;
      out_slot_ff  <= out_slot_in;
      out_level_ff <= out_level_in;
      out_err_ff   <= out_err_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_tvalid  = out_valid_ff;
   assign result_kind = out_kind_ff;
   assign slot_number = out_slot_ff;
   assign level       = out_level_ff;
   assign query_error = out_err_ff;
   assign last        = out_last_ff;

endmodule

// ===== hw/rtl/virtual_wire_signal_mirror.sv =====
// top level of the virtual wire signal mirror
//
//   channel  direction  words
//   req_     in         one bus event, initial value or query
//   rsp_     out        change notifications and query replies
//   csr_     in         settings writes, no read-back
//
// a word with no result leaves the block ready for the next word; a query
// enters the run state and puts its reply into the output register. a bus
// reset release or a received wire scans the slots with one counter step per
// cycle. the scan stalls while the output register holds a word that is not
// taken. synchronous reset clears the slot state, the settings and the
// output register.
module virtual_wire_signal_mirror
   import vwsm_pkg::*;
#(
   parameter int NUM_SIGNALS = 8
) (
   input  logic               clock,
   input  logic               reset,
   // settings port
   input  logic               csr_we,
   input  logic [CSR_A_W-1:0] csr_addr,
   input  logic [CSR_D_W-1:0] csr_wdata,
   // request channel
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [REQ_D_W-1:0] req_tdata,  // event_level, is_wire_channel, wire_id, slot_index
   input  logic [TYPE_W-1:0]  req_tuser,  // req_type
   // result channel
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [RSP_D_W-1:0] rsp_tdata,  // slot_number, level, query_error
   output logic               rsp_tuser,  // result_kind
   output logic               rsp_tlast
);

   cmd_type           cmd;
   status_type        sts;
   logic [SLOT_W-1:0] slot_number;
   logic              level;
   logic              query_error;

   vwsm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   vwsm_dp #(
      .NUM_SIGNALS (NUM_SIGNALS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_addr        (csr_addr),
      .csr_wdata       (csr_wdata),
      .req_type        (req_tuser),
      .event_level     (req_tdata[0]),
      .is_wire_channel (req_tdata[1]),
      .wire_id         (req_tdata[9:2]),
      .slot_index      (req_tdata[17:10]),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .result_kind     (rsp_tuser),
      .slot_number     (slot_number),
      .level           (level),
      .query_error     (query_error),
      .last            (rsp_tlast)
   );

   // pack the result word, zero fill to the byte
   assign rsp_tdata = {3'b000, query_error, level, slot_number};

endmodule

// ===== dv/virtual_wire_signal_mirror_tb.sv =====
// self-checking testbench of the virtual wire signal mirror
`timescale 1ns / 100ps

module virtual_wire_signal_mirror_tb;
   import vwsm_pkg::*;

   localparam int SLOTS = 8;
   localparam int WORDS_PER_PHASE = 80;
   localparam int PHASES = 6;
   localparam int SETTLE_CYCLES = 2 * SLOTS + 8;
   localparam int CYCLE_LIMIT = 900000;

   // request types the block ignores
   localparam logic [2:0] REQ_SPARE_LO  = 3'd5;
   localparam logic [2:0] REQ_SPARE_MID = 3'd6;
   localparam logic [2:0] REQ_SPARE_HI  = 3'd7;

   typedef struct packed {
      logic [2:0] kind;
      logic       lvl;
      logic       chan;
      logic [7:0] wid;
      logic [7:0] idx;
   } req_word_t;

   typedef struct packed {
      logic       kind;
      logic [2:0] slot;
      logic       level;
      logic       err;
      logic       last;
   } rsp_word_t;

   typedef struct {
      req_word_t word;
      bit        typed;
      rsp_word_t want;
   } stim_row_t;

   logic               clock;
   logic               reset;
   logic               csr_we;
   logic [CSR_A_W-1:0] csr_addr;
   logic [CSR_D_W-1:0] csr_wdata;
   logic               req_tvalid;
   logic               req_tready;
   logic [REQ_D_W-1:0] req_tdata;  // event_level, is_wire_channel, wire_id, slot_index
   logic [TYPE_W-1:0]  req_tuser;  // req_type
   logic               rsp_tvalid;
   logic               rsp_tready;
   logic [RSP_D_W-1:0] rsp_tdata;  // slot_number, level, query_error
   logic               rsp_tuser;  // result_kind
   logic               rsp_tlast;

   // mirror of the block's settings and slot state
   logic [63:0] cfg_wire_map;
   logic [7:0]  cfg_invert;
   logic [7:0]  cfg_reset_lvl;
   logic [7:0]  slot_level;
   logic [7:0]  slot_valid;

   rsp_word_t due_words[$];
   stim_row_t stim_table[$];
   int        fail_count;
   int        cycle_count;
   bit        quiet;
   int        stall_left;

   virtual_wire_signal_mirror #(
      .NUM_SIGNALS(SLOTS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_addr(csr_addr),
      .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // run limit
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // store one slot, inverted as configured
   function automatic logic latch_slot(input int s, input logic data);
      logic v;
      v = data ^ cfg_invert[s];
      slot_level[s] = v;
      slot_valid[s] = 1'b1;
      return v;
   endfunction

   // advance the slot state by one word and, when keep is set, queue the words it must produce
   function automatic void mirror_step(input req_word_t w, input bit keep);
      rsp_word_t found[$];
      logic      v;
      int        s;
      case (w.kind)
         REQ_BUS_RESET: begin
            if (!w.lvl) begin
               slot_valid = '0;
            end else begin
               for (s = 0; s < SLOTS; s++) begin
                  v = latch_slot(s, cfg_reset_lvl[s] ^ cfg_invert[s]);
                  found.push_back('{KIND_NOTIFY, s[2:0], v, 1'b0, 1'b0});
               end
            end
         end
         REQ_CHAN_STATUS: begin
            if (w.chan && !w.lvl)
               slot_valid = '0;
         end
         REQ_WIRE_RX: begin
            for (s = 0; s < SLOTS; s++) begin
               if (cfg_wire_map[8*s +: 8] == w.wid) begin
                  v = latch_slot(s, w.lvl);
                  found.push_back('{KIND_NOTIFY, s[2:0], v, 1'b0, 1'b0});
               end
            end
         end
         REQ_INIT_VALUE: begin
            if (w.idx < SLOTS)
               v = latch_slot(int'(w.idx), w.lvl);
         end
         REQ_QUERY: begin
            if (w.idx >= SLOTS)
               found.push_back('{KIND_REPLY, 3'd0, 1'b0, 1'b1, 1'b0});
            else if (!slot_valid[w.idx[2:0]])
               found.push_back('{KIND_REPLY, w.idx[2:0], 1'b0, 1'b1, 1'b0});
            else
               found.push_back('{KIND_REPLY, w.idx[2:0], slot_level[w.idx[2:0]], 1'b0, 1'b0});
         end
         default: begin
         end
      endcase
      if (found.size() > 0)
         found[found.size()-1].last = 1'b1;
      if (keep)
         foreach (found[i]) due_words.push_back(found[i]);
   endfunction

   // error reply for one slot, always the last word of its query
   function automatic rsp_word_t err_reply(input logic [2:0] slot);
      return '{KIND_REPLY, slot, 1'b0, 1'b1, 1'b1};
   endfunction

   function automatic void add_row(input logic [2:0] kind, input logic lvl, input logic chan,
                                   input logic [7:0] wid, input logic [7:0] idx,
                                   input bit typed, input rsp_word_t want);
      stim_row_t r;
      r.word  = '{kind, lvl, chan, wid, idx};
      r.typed = typed;
      r.want  = want;
      stim_table.push_back(r);
   endfunction

   // one settings write, mirrored in the predictor
   task automatic write_csr(input logic [CSR_A_W-1:0] addr, input logic [63:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value;
      @(posedge clock);
      case (addr)
         CSR_WIRE_ID_MAP: cfg_wire_map  = value;
         CSR_INVERT_MASK: cfg_invert    = value[7:0];
         CSR_RESET_LEVEL: cfg_reset_lvl = value[7:0];
         default: begin
         end
      endcase
   endtask

   task automatic set_config(input logic [63:0] map, input logic [7:0] inv,
                             input logic [7:0] rst_lvl);
      write_csr(CSR_WIRE_ID_MAP, map);
      write_csr(CSR_INVERT_MASK, {56'd0, inv});
      write_csr(CSR_RESET_LEVEL, {56'd0, rst_lvl});
      csr_we <= 1'b0;
   endtask

   // wait until every due word has come and the block has gone quiet
   task automatic drain();
      while (due_words.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // present one word, with an occasional idle burst ahead of it
   task automatic send_word(input req_word_t w, input bit typed, input rsp_word_t want);
      int gap;
      if (!quiet && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 18);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= w.kind;
      req_tdata  <= {6'd0, w.idx, w.wid, w.chan, w.lvl};
      do
         @(posedge clock);
      while (!req_tready);
      mirror_step(w, !typed);
      if (typed)
         due_words.push_back(want);
   endtask

   // random word, mostly aimed at configured wire ids and real slots
   function automatic req_word_t random_word();
      req_word_t w;
      int        pick;
      pick   = $urandom_range(0, 99);
      w.lvl  = 1'($urandom_range(0, 1));
      w.chan = 1'($urandom_range(0, 1));
      w.wid  = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 4) == 0)
         w.idx = 8'($urandom_range(0, 255));
      else
         w.idx = 8'($urandom_range(0, SLOTS - 1));
      if (pick < 12) begin
         w.kind = REQ_BUS_RESET;
         w.lvl  = ($urandom_range(0, 9) < 6);
      end else if (pick < 22) begin
         w.kind = REQ_CHAN_STATUS;
      end else if (pick < 58) begin
         w.kind = REQ_WIRE_RX;
         if ($urandom_range(0, 3) != 0)
            w.wid = cfg_wire_map[8*$urandom_range(0, SLOTS - 1) +: 8];
      end else if (pick < 68) begin
         w.kind = REQ_INIT_VALUE;
      end else if (pick < 96) begin
         w.kind = REQ_QUERY;
      end else begin
         w.kind = REQ_SPARE_LO + 3'($urandom_range(0, 2));
      end
      return w;
   endfunction

   // result side stalls in random bursts
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(0, 17);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endfunction

   // compare each accepted result word with the oldest one due
   always @(posedge clock) begin
      rsp_word_t exp_word;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (due_words.size() == 0) begin
            $error("unexpected result word: kind %0d slot %0d", rsp_tuser, rsp_tdata[2:0]);
            fail_count++;
         end else begin
            exp_word = due_words.pop_front();
            check_field("result_kind", exp_word.kind, rsp_tuser);
            check_field("slot_number", exp_word.slot, rsp_tdata[2:0]);
            check_field("level", exp_word.level, rsp_tdata[3]);
            check_field("query_error", exp_word.err, rsp_tdata[4]);
            check_field("last", exp_word.last, rsp_tlast);
         end
      end
   end

   // main sequence
   initial begin
      rsp_word_t   none;
      logic [7:0]  id_pool[4];
      logic [63:0] map;
      none        = '0;
      fail_count  = 0;
      quiet       = 1'b0;
      stall_left  = 0;
      slot_level  = '0;
      slot_valid  = '0;
      cfg_wire_map  = '0;
      cfg_invert    = '0;
      cfg_reset_lvl = '0;
      reset      <= 1'b1;
      csr_we     <= 1'b0;
      csr_addr   <= '0;
      csr_wdata  <= '0;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      rsp_tready <= 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: error replies from the reset state, ignored words, then slot updates
      add_row(REQ_QUERY, 1'b0, 1'b0, 8'h00, 8'd0, 1, err_reply(3'd0));
      add_row(REQ_QUERY, 1'b0, 1'b0, 8'h00, 8'd255, 1, err_reply(3'd0));
      add_row(REQ_QUERY, 1'b1, 1'b1, 8'hFF, 8'd8, 1, err_reply(3'd0));
      add_row(REQ_QUERY, 1'b0, 1'b0, 8'h00, 8'd7, 1, err_reply(3'd7));
      add_row(REQ_SPARE_LO, 1'b1, 1'b1, 8'h00, 8'd0, 0, none);
      add_row(REQ_SPARE_MID, 1'b1, 1'b1, 8'h21, 8'd1, 0, none);
      add_row(REQ_SPARE_HI, 1'b1, 1'b1, 8'hFF, 8'd255, 0, none);
      add_row(REQ_INIT_VALUE, 1'b1, 1'b0, 8'h00, 8'd255, 0, none);
      add_row(REQ_INIT_VALUE, 1'b1, 1'b0, 8'h00, 8'd8, 0, none);
      add_row(REQ_BUS_RESET, 1'b1, 1'b0, 8'h00, 8'd0, 0, none);
      add_row(REQ_QUERY, 1'b0, 1'b0, 8'h00, 8'd2, 0, none);
      add_row(REQ_WIRE_RX, 1'b1, 1'b0, 8'h21, 8'd0, 0, none);
      add_row(REQ_WIRE_RX, 1'b0, 1'b0, 8'hFF, 8'd0, 0, none);
      add_row(REQ_WIRE_RX, 1'b1, 1'b0, 8'h00, 8'd0, 0, none);
      add_row(REQ_WIRE_RX, 1'b1, 1'b0, 8'h55, 8'd0, 0, none);
      add_row(REQ_CHAN_STATUS, 1'b0, 1'b0, 8'h00, 8'd0, 0, none);
      add_row(REQ_CHAN_STATUS, 1'b1, 1'b1, 8'h00, 8'd0, 0, none);
      add_row(REQ_QUERY, 1'b0, 1'b0, 8'h00, 8'd5, 0, none);
      add_row(REQ_CHAN_STATUS, 1'b0, 1'b1, 8'h00, 8'd0, 0, none);
      add_row(REQ_QUERY, 1'b0, 1'b0, 8'h00, 8'd3, 1, err_reply(3'd3));
      add_row(REQ_INIT_VALUE, 1'b1, 1'b0, 8'h00, 8'd3, 0, none);
      add_row(REQ_QUERY, 1'b0, 1'b0, 8'h00, 8'd3, 0, none);
      add_row(REQ_BUS_RESET, 1'b0, 1'b0, 8'h00, 8'd0, 0, none);
      add_row(REQ_QUERY, 1'b0, 1'b0, 8'h00, 8'd7, 1, err_reply(3'd7));

      set_config(64'h01_7F_80_21_21_21_FF_00, 8'hA5, 8'h3C);
      foreach (stim_table[i])
         send_word(stim_table[i].word, stim_table[i].typed, stim_table[i].want);
      req_tvalid <= 1'b0;

      // random phases, each under its own settings, the first two at the extremes
      for (int phase = 0; phase < PHASES; phase++) begin
         drain();
         if (phase == 0) begin
            set_config('0, 8'h00, 8'h00);
         end else if (phase == 1) begin
            set_config('1, 8'hFF, 8'hFF);
         end else begin
            foreach (id_pool[j]) id_pool[j] = 8'($urandom_range(0, 255));
            for (int s = 0; s < SLOTS; s++)
               map[8*s +: 8] = id_pool[$urandom_range(0, 3)];
            set_config(map, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
         end
         if (phase == PHASES - 1)
            quiet = 1'b1;
         for (int n = 0; n < WORDS_PER_PHASE; n++)
            send_word(random_word(), 0, none);
         req_tvalid <= 1'b0;
      end

      drain();
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
